// ----- sv/bcg_pkg.sv -----
// ----------------------------------------------------------------------------
// bcg_pkg
// shared types, register map and event codes of the button gesture detector
// ----------------------------------------------------------------------------
package bcg_pkg;

  // millisecond timer width, 8 to 32
  localparam int unsigned TIMER_W = 16;
  // width used for threshold compares and the held time clamp
  localparam int unsigned CMP_W   = (TIMER_W > 16) ? TIMER_W : 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [7:0]         CLICK_MAX = 8'hFF;

  // register map, index into paddr[4:2]
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_ACTIVE_LOW  = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd1;
  localparam logic [2:0] REG_LONG_CLICK  = 3'd2;
  localparam logic [2:0] REG_LONG_REPEAT = 3'd3;
  localparam logic [2:0] REG_MULTICLICK  = 3'd4;

  // reset values of the registers
  localparam logic        RST_ACTIVE_LOW  = 1'b1;
  localparam logic [7:0]  RST_DEBOUNCE    = 8'd20;
  localparam logic [15:0] RST_LONG_CLICK  = 16'd1000;
  localparam logic [15:0] RST_LONG_REPEAT = 16'd200;
  localparam logic [15:0] RST_MULTICLICK  = 16'd400;

  // command carried by the action field
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    EV_PRESSED        = 3'd0,
    EV_LONG_FIRST     = 3'd1,
    EV_LONG_REPEAT    = 3'd2,
    EV_LONG_FINISH    = 3'd3,
    EV_CLICK_RELEASED = 3'd4,
    EV_CLICK_FINISH   = 3'd5
  } event_t;

  typedef struct packed {
    logic        active_low;
    logic [7:0]  debounce_len;
    logic [15:0] long_click_ms;
    logic [15:0] long_repeat_ms;
    logic [15:0] multiclick_len;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    event_t      code;
    logic [7:0]  clicks;
    logic [15:0] held;
  } ev_t;

endpackage

// ----- sv/bcg_cfg.sv -----
// ----------------------------------------------------------------------------
// bcg_cfg
// apb register file holding the timing thresholds and the pin polarity
// ----------------------------------------------------------------------------
module bcg_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcg_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output bcg_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low     <= bcg_pkg::RST_ACTIVE_LOW;
      cfg.debounce_len   <= bcg_pkg::RST_DEBOUNCE;
      cfg.long_click_ms  <= bcg_pkg::RST_LONG_CLICK;
      cfg.long_repeat_ms <= bcg_pkg::RST_LONG_REPEAT;
      cfg.multiclick_len <= bcg_pkg::RST_MULTICLICK;
    end else if (wr_en) begin
      case (reg_idx)
        bcg_pkg::REG_ACTIVE_LOW:  cfg.active_low     <= pwdata[0];
        bcg_pkg::REG_DEBOUNCE:    cfg.debounce_len   <= pwdata[7:0];
        bcg_pkg::REG_LONG_CLICK:  cfg.long_click_ms  <= pwdata[15:0];
        bcg_pkg::REG_LONG_REPEAT: cfg.long_repeat_ms <= pwdata[15:0];
        bcg_pkg::REG_MULTICLICK:  cfg.multiclick_len <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bcg_pkg::REG_ACTIVE_LOW:  prdata = {31'd0, cfg.active_low};
      bcg_pkg::REG_DEBOUNCE:    prdata = {24'd0, cfg.debounce_len};
      bcg_pkg::REG_LONG_CLICK:  prdata = {16'd0, cfg.long_click_ms};
      bcg_pkg::REG_LONG_REPEAT: prdata = {16'd0, cfg.long_repeat_ms};
      bcg_pkg::REG_MULTICLICK:  prdata = {16'd0, cfg.multiclick_len};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/bcg_core.sv -----
// ----------------------------------------------------------------------------
// bcg_core
// gesture state, saturating timers and the per-tick event decision
// ----------------------------------------------------------------------------
module bcg_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic          action,
  input  logic          level,
  input  bcg_pkg::cfg_t cfg,
  output bcg_pkg::ev_t  ev
);

  logic [bcg_pkg::TIMER_W-1:0] press_timer, press_timer_next;
  logic [bcg_pkg::TIMER_W-1:0] repeat_timer, repeat_timer_next;
  logic                        last_level, last_level_next;
  logic                        press_reported, press_reported_next;
  logic                        long_seen, long_seen_next;
  logic [7:0]                  clicks, clicks_next;
  logic [15:0]                 held_time, held_time_next;

  logic [bcg_pkg::TIMER_W-1:0] pt_adv, rt_adv;
  logic [bcg_pkg::CMP_W-1:0]   pt_ext, rt_ext;
  logic [15:0]                 pt_held;
  logic                        pressed_level;
  logic [7:0]                  clicks_inc;

  assign pressed_level = ~cfg.active_low;
  assign pt_adv = (press_timer == bcg_pkg::TIMER_MAX) ? press_timer
                                                      : press_timer + 1'b1;
  assign rt_adv = (repeat_timer == bcg_pkg::TIMER_MAX) ? repeat_timer
                                                       : repeat_timer + 1'b1;
  assign pt_ext = bcg_pkg::CMP_W'(pt_adv);
  assign rt_ext = bcg_pkg::CMP_W'(rt_adv);
  // press duration clamped to 16 bits
  assign pt_held = (pt_ext > bcg_pkg::CMP_W'(16'hFFFF)) ? 16'hFFFF : pt_ext[15:0];
  assign clicks_inc = (clicks == bcg_pkg::CLICK_MAX) ? clicks : clicks + 8'd1;

  always_comb begin
    press_timer_next    = pt_adv;
    repeat_timer_next   = rt_adv;
    last_level_next     = level;
    press_reported_next = press_reported;
    long_seen_next      = long_seen;
    clicks_next         = clicks;
    held_time_next      = held_time;
    ev.valid            = 1'b0;
    ev.code             = bcg_pkg::EV_PRESSED;
    ev.clicks           = clicks;

    if (action == bcg_pkg::ACT_CLEAR) begin
      press_timer_next    = '0;
      repeat_timer_next   = '0;
      last_level_next     = last_level;
      press_reported_next = 1'b0;
      long_seen_next      = 1'b0;
      clicks_next         = 8'd0;
    end else if (level == pressed_level) begin
      if (last_level != pressed_level) begin
        // press edge
        press_timer_next    = '0;
        repeat_timer_next   = '0;
        press_reported_next = 1'b0;
        long_seen_next      = 1'b0;
      end else if (!press_reported && pt_ext >= bcg_pkg::CMP_W'(cfg.debounce_len)) begin
        press_reported_next = 1'b1;
        clicks_next         = clicks_inc;
        ev.valid            = 1'b1;
        ev.code             = bcg_pkg::EV_PRESSED;
        ev.clicks           = clicks_inc;
      end else if (press_reported && clicks == 8'd1) begin
        if (!long_seen && pt_ext >= bcg_pkg::CMP_W'(cfg.long_click_ms)) begin
          held_time_next    = pt_held;
          long_seen_next    = 1'b1;
          repeat_timer_next = '0;
          ev.valid          = 1'b1;
          ev.code           = bcg_pkg::EV_LONG_FIRST;
        end else if (long_seen && rt_ext >= bcg_pkg::CMP_W'(cfg.long_repeat_ms)) begin
          held_time_next    = pt_held;
          repeat_timer_next = '0;
          ev.valid          = 1'b1;
          ev.code           = bcg_pkg::EV_LONG_REPEAT;
        end
      end
    end else if (press_reported) begin
      if (last_level == pressed_level) begin
        // release edge
        held_time_next = pt_held;
        ev.valid       = 1'b1;
        if (clicks == 8'd1 && long_seen) begin
          ev.code             = bcg_pkg::EV_LONG_FINISH;
          long_seen_next      = 1'b0;
          press_reported_next = 1'b0;
          clicks_next         = 8'd0;
        end else begin
          ev.code = bcg_pkg::EV_CLICK_RELEASED;
        end
      end else if (clicks != 8'd0 && pt_ext >= bcg_pkg::CMP_W'(cfg.multiclick_len)) begin
        ev.valid            = 1'b1;
        ev.code             = bcg_pkg::EV_CLICK_FINISH;
        press_reported_next = 1'b0;
        clicks_next         = 8'd0;
      end
    end
    ev.held = held_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_timer    <= '0;
      repeat_timer   <= '0;
      last_level     <= bcg_pkg::RST_ACTIVE_LOW;
      press_reported <= 1'b0;
      long_seen      <= 1'b0;
      clicks         <= 8'd0;
      held_time      <= 16'd0;
    end else if (go) begin
      press_timer    <= press_timer_next;
      repeat_timer   <= repeat_timer_next;
      last_level     <= last_level_next;
      press_reported <= press_reported_next;
      long_seen      <= long_seen_next;
      clicks         <= clicks_next;
      held_time      <= held_time_next;
    end
  end

endmodule

// ----- sv/button_click_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// button_click_gesture_detector
// debounce, multi-click and long-press detection on one millisecond tick stream
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  in       | in        | in_valid / in_stall | action, pin_level
//  out      | out       | out_valid/out_stall | event_code, click_count,
//           |           |                     | pressed_time_ms
//  apb      | in        | psel/penable/pready | paddr, pwdata, prdata (5 registers)
//
//  a tick transaction waits in the input register until the output register is free
//  or being drained; its event (if any) is then offered from the output register
//  one tick per cycle sustained while the output is not stalled; the limit is the state update
//  a stalled output only holds the input register once both registers are full
//  synchronous active-high reset returns thresholds and gesture state to
//  their defaults, last level to the released level
// ----------------------------------------------------------------------------
module button_click_gesture_detector (
  input  logic                        clk,
  input  logic                        rst,
  // tick channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic                        pin_level,
  // event channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  event_code,
  output logic [7:0]                  click_count,
  output logic [15:0]                 pressed_time_ms,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  bcg_pkg::cfg_t cfg;
  bcg_pkg::ev_t  ev;

  // input register
  logic in_valid_q;
  logic in_action_q;
  logic in_level_q;

  logic go;
  logic in_take;

  // evaluate the held tick when the output register is free or being drained
  assign go       = in_valid_q && (!out_valid || !out_stall);
  assign in_stall = in_valid_q && !go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_q <= action;
      in_level_q  <= pin_level;
    end
  end

  bcg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .action (in_action_q),
    .level  (in_level_q),
    .cfg    (cfg),
    .ev     (ev)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= ev.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ev.valid) begin
      event_code      <= ev.code;
      click_count     <= ev.clicks;
      pressed_time_ms <= ev.held;
    end
  end

  // stall only ever comes from a full pipe behind a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_valid_q && out_valid && out_stall))
    else $error("input stalled without a blocked output");

  // a pressed event always counts at least one click
  a_pressed_clicks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_code == bcg_pkg::EV_PRESSED) |-> (click_count != 8'd0))
    else $error("pressed event with zero clicks");

  // long click events belong to a single-click sequence
  a_long_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_code == bcg_pkg::EV_LONG_FIRST ||
                   event_code == bcg_pkg::EV_LONG_REPEAT ||
                   event_code == bcg_pkg::EV_LONG_FINISH)) |-> (click_count == 8'd1))
    else $error("long click event outside a single click");

  // a held tick never sits past a free output
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (in_valid_q && !out_valid) |=> !$past(in_stall))
    else $error("tick held with output free");

endmodule
